// ===== design/bse_pkg.sv =====
// Package with the shared types and constants of the bitmap set engine.
`timescale 1ns / 1ps

package bse_pkg;

    localparam int ELEM_W   = 16;
    localparam int CHOSEN_W = 10;
    localparam int STATUS_W = 2;
    localparam int FUNC_W   = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT    = 4'd0,
        FN_DELETE    = 4'd1,
        FN_MEMBER    = 4'd2,
        FN_EMPTY     = 4'd3,
        FN_CHOOSE    = 4'd4,
        FN_CLEAR     = 4'd5,
        FN_COPY      = 4'd6,
        FN_UNION     = 4'd7,
        FN_INTERSECT = 4'd8,
        FN_SUBSET    = 4'd9,
        FN_EQUAL     = 4'd10,
        FN_DISJOINT  = 4'd11
    } func_t;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_RMW,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              slot;
        logic [ELEM_W-1:0] element;
    } in_word_t;

    typedef struct packed {
        logic                answer;
        logic [CHOSEN_W-1:0] chosen;
        logic [STATUS_W-1:0] status;
    } out_word_t;

endpackage

// ===== design/bse_locate.sv =====
// Element locator: splits an element into word index and bit position.
`timescale 1ns / 1ps

module bse_locate #(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 32,
    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int BW = $clog2(WORD_BITS)
) (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [bse_pkg::ELEM_W-1:0]        element,
    output logic [AW-1:0]                     word_idx,
    output logic [BW-1:0]                     bit_pos,
    output logic                              in_range
);

    localparam int EW = bse_pkg::ELEM_W;
    localparam int RECIP_SHIFT = 32;
    localparam int RW = 34;
    localparam int PW = EW + RW;
    // Rounded-up reciprocal; exact for every 16-bit element at these word sizes.
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RECIP_SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
    localparam logic [EW-1:0] WB_C = EW'(WORD_BITS);
    localparam logic [EW:0]   NW_C = (EW + 1)'(NUM_WORDS);

    logic [PW-1:0] prod;
    logic [EW-1:0] quot_reg;
    logic [EW-1:0] elem_reg;
    logic [EW-1:0] base;
    logic [EW-1:0] rem;

    assign prod = PW'(element) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        if (load) begin
            quot_reg <= prod[RECIP_SHIFT +: EW];
            elem_reg <= element;
        end
    end

    assign base     = quot_reg * WB_C;
    assign rem      = elem_reg - base;
    assign word_idx = quot_reg[AW-1:0];
    assign bit_pos  = rem[BW-1:0];
    assign in_range = ({1'b0, quot_reg} < NW_C);

endmodule

// ===== design/bitmap_set_engine_core.sv =====
// Top level of the bitmap set engine: two bitmap sets kept in two word memories.
`timescale 1ns / 1ps

// The block keeps two sets of small integers, each NUM_WORDS words of WORD_BITS
// bits in its own single-port-per-side memory, so elements 0 to
// NUM_WORDS*WORD_BITS-1 can be stored. Commands enter on the s_ channel
// (s_valid, s_ready, s_data) and every command returns exactly one result word
// on the m_ channel (m_valid, m_ready, m_data).
// Insert, delete and member pass through the ACCESS, RMW and DONE states: the
// element is split into word and bit through a registered reciprocal
// multiply, then the word is read, modified and written back.
// Whole-set commands (empty, choose, clear, copy, union, intersect, subset,
// equal, disjoint) walk both memories one word per cycle in the SWEEP state.
// Commands codes 12 to 15 go straight to the DONE state with an all-zero result.
// One command is worked on at a time; s_ready comes back as soon as the
// result has moved into the output register, so a new command can start
// while the previous result is still waiting for m_ready.
// If the receiver stalls with a result still held, a finished command waits
// in its last step and s_ready stays low until the output register frees up.
// After reset both memories are cleared by a pass over every word, during which
// s_ready is low; m_valid is low after reset.

module bitmap_set_engine_core #(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bse_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bse_pkg::out_word_t  m_data
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int VW = bse_pkg::ELEM_W + 1;
    localparam logic [AW:0] CNT_LAST = (AW + 1)'(NUM_WORDS - 1);
    localparam logic [AW:0] CNT_END  = (AW + 1)'(NUM_WORDS);

    // Set storage, one memory per set.
    logic [WORD_BITS-1:0] mem0 [NUM_WORDS];
    logic [WORD_BITS-1:0] mem1 [NUM_WORDS];

    bse_pkg::state_t    state_reg, state_next;
    bse_pkg::func_t     func_reg;
    bse_pkg::func_t     s_func;
    logic               slot_reg;
    logic [AW:0]        cnt_reg;
    logic [BW-1:0]      bitpos_reg;
    logic               inrange_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               rd_valid_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [WORD_BITS-1:0] q0_reg, q1_reg;

    logic               wr0, wr1;
    logic [AW-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic               ans_reg;
    logic               found_reg;
    logic [WORD_BITS-1:0] found_word_reg;
    logic [AW-1:0]      found_idx_reg;

    logic               out_valid_reg;
    bse_pkg::out_word_t out_reg, out_next;
    logic               out_load;
    logic               accept;
    logic               loc_load;

    logic [AW-1:0]      loc_word;
    logic [BW-1:0]      loc_bit;
    logic               loc_in_range;

    logic [WORD_BITS-1:0] a_word, b_word, onehot;
    logic [WORD_BITS-1:0] mod_word;
    logic                 mod_write;

    logic [WORD_BITS-1:0] lowest;
    logic [BW-1:0]        enc;
    logic [VW-1:0]        chosen_val;

    assign s_func = bse_pkg::func_t'(s_data.func);
    assign accept = s_valid && s_ready;

    bse_locate #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_locate (
        .aclk     (aclk),
        .load     (loc_load),
        .element  (s_data.element),
        .word_idx (loc_word),
        .bit_pos  (loc_bit),
        .in_range (loc_in_range)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bse_pkg::S_CLEAR: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = bse_pkg::S_IDLE;
                end
            end
            bse_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_func inside {bse_pkg::FN_INSERT, bse_pkg::FN_DELETE,
                                       bse_pkg::FN_MEMBER}) begin
                        state_next = bse_pkg::S_ACCESS;
                    end else if (s_func inside {[bse_pkg::FN_EMPTY :
                                                 bse_pkg::FN_DISJOINT]}) begin
                        state_next = bse_pkg::S_SWEEP;
                    end else begin
                        state_next = bse_pkg::S_DONE;
                    end
                end
            end
            bse_pkg::S_ACCESS: state_next = bse_pkg::S_RMW;
            bse_pkg::S_RMW:    state_next = bse_pkg::S_DONE;
            bse_pkg::S_SWEEP: begin
                if (cnt_reg == CNT_END) begin
                    state_next = bse_pkg::S_DONE;
                end
            end
            bse_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = bse_pkg::S_IDLE;
                end
            end
            default: state_next = bse_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        loc_load = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = cnt_reg[AW-1:0];
        out_load = 1'b0;
        case (state_reg)
            bse_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                loc_load = s_valid;
            end
            bse_pkg::S_ACCESS: begin
                rd_en   = loc_in_range;
                rd_addr = loc_word;
            end
            bse_pkg::S_SWEEP: begin
                rd_en = (cnt_reg < CNT_END);
            end
            bse_pkg::S_DONE: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Word modify: the data read last cycle is combined and written back
    // to the same address in the selected set.
    assign a_word = slot_reg ? q1_reg : q0_reg;
    assign b_word = slot_reg ? q0_reg : q1_reg;
    assign onehot = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bitpos_reg;

    always_comb begin
        mod_word  = a_word;
        mod_write = 1'b0;
        case (func_reg)
            bse_pkg::FN_INSERT: begin
                mod_word  = a_word | onehot;
                mod_write = 1'b1;
            end
            bse_pkg::FN_DELETE: begin
                mod_word  = a_word & ~onehot;
                mod_write = 1'b1;
            end
            bse_pkg::FN_CLEAR: begin
                mod_word  = '0;
                mod_write = 1'b1;
            end
            bse_pkg::FN_COPY: begin
                mod_word  = b_word;
                mod_write = 1'b1;
            end
            bse_pkg::FN_UNION: begin
                mod_word  = a_word | b_word;
                mod_write = 1'b1;
            end
            bse_pkg::FN_INTERSECT: begin
                mod_word  = a_word & b_word;
                mod_write = 1'b1;
            end
            default: begin
                mod_write = 1'b0;
            end
        endcase
    end

    // During the reset clearing pass both memories take zeros at the counter.
    always_comb begin
        if (state_reg == bse_pkg::S_CLEAR) begin
            wr0     = 1'b1;
            wr1     = 1'b1;
            wr_addr = cnt_reg[AW-1:0];
            wr_data = '0;
        end else begin
            wr0     = rd_valid_reg && mod_write && !slot_reg;
            wr1     = rd_valid_reg && mod_write && slot_reg;
            wr_addr = rd_idx_reg;
            wr_data = mod_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q0_reg <= mem0[rd_addr];
            q1_reg <= mem1[rd_addr];
        end
        if (wr0) begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr1) begin
            mem1[wr_addr] <= wr_data;
        end
    end

    // Lowest set bit of the first nonzero word, for choose.
    assign lowest = found_word_reg & (~found_word_reg + {{(WORD_BITS - 1){1'b0}}, 1'b1});

    always_comb begin
        enc = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                enc = enc | BW'(i);
            end
        end
    end

    assign chosen_val = VW'(found_idx_reg) * VW'(WORD_BITS) + VW'(enc);

    always_comb begin
        out_next        = '0;
        out_next.answer = ans_reg;
        if (func_reg == bse_pkg::FN_INSERT && !inrange_reg) begin
            out_next.status = bse_pkg::STAT_FULL;
        end
        if (func_reg == bse_pkg::FN_CHOOSE) begin
            if (found_reg) begin
                out_next.chosen = chosen_val[bse_pkg::CHOSEN_W-1:0];
            end else begin
                out_next.status = bse_pkg::STAT_EMPTY;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bse_pkg::S_CLEAR;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (accept) begin
                cnt_reg <= '0;
            end else if (state_reg == bse_pkg::S_CLEAR ||
                         (state_reg == bse_pkg::S_SWEEP && cnt_reg < CNT_END)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command and accumulator registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        if (accept) begin
            func_reg    <= s_func;
            slot_reg    <= s_data.slot;
            found_reg   <= 1'b0;
            inrange_reg <= 1'b1;
            ans_reg     <= (s_func inside {bse_pkg::FN_EMPTY, bse_pkg::FN_SUBSET,
                                           bse_pkg::FN_EQUAL, bse_pkg::FN_DISJOINT});
        end else begin
            if (state_reg == bse_pkg::S_ACCESS) begin
                bitpos_reg  <= loc_bit;
                inrange_reg <= loc_in_range;
            end
            if (rd_valid_reg) begin
                case (func_reg)
                    bse_pkg::FN_MEMBER: begin
                        ans_reg <= |(a_word & onehot);
                    end
                    bse_pkg::FN_EMPTY: begin
                        if (|a_word) begin
                            ans_reg <= 1'b0;
                        end
                    end
                    bse_pkg::FN_SUBSET: begin
                        if (|(a_word & ~b_word)) begin
                            ans_reg <= 1'b0;
                        end
                    end
                    bse_pkg::FN_EQUAL: begin
                        if (|(a_word ^ b_word)) begin
                            ans_reg <= 1'b0;
                        end
                    end
                    bse_pkg::FN_DISJOINT: begin
                        if (|(a_word & b_word)) begin
                            ans_reg <= 1'b0;
                        end
                    end
                    bse_pkg::FN_CHOOSE: begin
                        if (!found_reg && |a_word) begin
                            found_reg      <= 1'b1;
                            found_word_reg <= a_word;
                            found_idx_reg  <= rd_idx_reg;
                        end
                    end
                    default: begin
                        ans_reg <= ans_reg;
                    end
                endcase
            end
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/bse_checker.sv =====
// Port-level checker for the bitmap set engine and its bind to the top level.
`timescale 1ns / 1ps

module bse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bse_pkg::out_word_t  m_data
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // One command at a time: the input closes right after a word is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after accepting a word");

    // The clearing pass after reset keeps the input closed and no result out.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

    // A new result only appears while a command was in progress.
    a_result_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared with no command in progress");

endmodule

bind bitmap_set_engine_core bse_checker u_bse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/bitmap_set_engine_core_tb.sv =====
// Self-checking testbench for the bitmap set engine core.
`timescale 1ns / 1ps

module bitmap_set_engine_core_tb;

    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = 32;
    localparam int CAPACITY    = WORD_BITS * NUM_WORDS;
    localparam int HOLD_CYCLES = 400;
    localparam logic [bse_pkg::FUNC_W-1:0] FUNC_SPARE_LO = bse_pkg::FN_DISJOINT + 4'd1;
    localparam logic [bse_pkg::FUNC_W-1:0] FUNC_SPARE_HI = {bse_pkg::FUNC_W{1'b1}};
    localparam logic [bse_pkg::ELEM_W-1:0] ELEM_TOP      = {bse_pkg::ELEM_W{1'b1}};

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bse_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bse_pkg::out_word_t m_data;

    // Shadow copy of both sets, one bit per element.
    bit [CAPACITY-1:0] shadow_sets [2];

    bse_pkg::in_word_t  cmd_queue[$];
    bse_pkg::out_word_t want_results[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  n_issued = 0;
    int  n_accepted = 0;
    int  err_cnt = 0;
    bit  hold_go = 1'b0;
    logic hold_on = 1'b0;

    bitmap_set_engine_core #(
        .WORD_BITS(WORD_BITS),
        .NUM_WORDS(NUM_WORDS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one command to the shadow sets and returns the result word it must produce.
    function automatic bse_pkg::out_word_t apply_command(bse_pkg::in_word_t cmd);
        bse_pkg::out_word_t res;
        bit [CAPACITY-1:0]  sel_set;
        bit [CAPACITY-1:0]  other_set;
        bit                 in_range;
        bit                 found;
        res       = '0;
        sel_set   = shadow_sets[cmd.slot];
        other_set = shadow_sets[!cmd.slot];
        in_range  = cmd.element < CAPACITY;
        found     = 1'b0;
        case (bse_pkg::func_t'(cmd.func))
            bse_pkg::FN_INSERT: begin
                if (in_range) sel_set[cmd.element] = 1'b1;
                else res.status = bse_pkg::STAT_FULL;
            end
            bse_pkg::FN_DELETE: begin
                if (in_range) sel_set[cmd.element] = 1'b0;
            end
            bse_pkg::FN_MEMBER: begin
                if (in_range) res.answer = sel_set[cmd.element];
            end
            bse_pkg::FN_EMPTY:  res.answer = (sel_set == '0);
            bse_pkg::FN_CHOOSE: begin
                // The smallest element wins; an empty set reports an error status.
                res.status = bse_pkg::STAT_EMPTY;
                for (int k = 0; k < CAPACITY; k++) begin
                    if (!found && sel_set[k]) begin
                        found      = 1'b1;
                        res.chosen = bse_pkg::CHOSEN_W'(k);
                        res.status = bse_pkg::STAT_OK;
                    end
                end
            end
            bse_pkg::FN_CLEAR:     sel_set = '0;
            bse_pkg::FN_COPY:      sel_set = other_set;
            bse_pkg::FN_UNION:     sel_set = sel_set | other_set;
            bse_pkg::FN_INTERSECT: sel_set = sel_set & other_set;
            bse_pkg::FN_SUBSET:    res.answer = ((sel_set & ~other_set) == '0);
            bse_pkg::FN_EQUAL:     res.answer = (sel_set == other_set);
            bse_pkg::FN_DISJOINT:  res.answer = ((sel_set & other_set) == '0);
            default: ;
        endcase
        shadow_sets[cmd.slot] = sel_set;
        return res;
    endfunction

    // Elements lean toward a small window so that sets overlap and tests see both answers.
    function automatic logic [bse_pkg::ELEM_W-1:0] pick_element();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return bse_pkg::ELEM_W'($urandom_range(0, 63));
        if (pick < 85) return bse_pkg::ELEM_W'($urandom_range(0, CAPACITY - 1));
        return bse_pkg::ELEM_W'($urandom_range(CAPACITY, ELEM_TOP));
    endfunction

    function automatic logic [bse_pkg::FUNC_W-1:0] pick_func();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return bse_pkg::FN_INSERT;
        if (pick < 40) return bse_pkg::FN_DELETE;
        if (pick < 50) return bse_pkg::FN_MEMBER;
        if (pick < 54) return bse_pkg::FN_EMPTY;
        if (pick < 62) return bse_pkg::FN_CHOOSE;
        if (pick < 65) return bse_pkg::FN_CLEAR;
        if (pick < 70) return bse_pkg::FN_COPY;
        if (pick < 76) return bse_pkg::FN_UNION;
        if (pick < 82) return bse_pkg::FN_INTERSECT;
        if (pick < 88) return bse_pkg::FN_SUBSET;
        if (pick < 93) return bse_pkg::FN_EQUAL;
        if (pick < 98) return bse_pkg::FN_DISJOINT;
        return bse_pkg::FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    endfunction

    task automatic queue_cmd(logic [bse_pkg::FUNC_W-1:0] func, logic slot,
                             logic [bse_pkg::ELEM_W-1:0] element);
        bse_pkg::in_word_t cmd;
        cmd.func    = func;
        cmd.slot    = slot;
        cmd.element = element;
        cmd_queue.push_back(cmd);
        n_issued++;
    endtask

    // Fills the command queue for one idling phase and waits until the driver has taken it all.
    task automatic run_phase(int send_pct, int stall_pct, int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_cmd(pick_func(), 1'($urandom_range(0, 1)), pick_element());
        while (cmd_queue.size() != 0) @(posedge aclk);
    endtask

    // Command driver: a word stays on the bus, unchanged, until the block accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want_results.push_back(apply_command(s_data));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= cmd_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every accepted result word is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        bse_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (want_results.size() == 0) begin
                    $error("result word with no command outstanding: %h", m_data);
                    err_cnt++;
                end else begin
                    want = want_results.pop_front();
                    if (m_data.answer !== want.answer) begin
                        $error("answer: expected %0d, got %0d", want.answer, m_data.answer);
                        err_cnt++;
                    end
                    if (m_data.chosen !== want.chosen) begin
                        $error("chosen: expected %0d, got %0d", want.chosen, m_data.chosen);
                        err_cnt++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        err_cnt++;
                    end
                end
            end
            m_ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off: the block fills up and has to back-pressure the sender.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: capacity edges, empty-set choose, every whole-set operation
        // and the spare function codes.
        queue_cmd(bse_pkg::FN_INSERT,    1'b0, '0);
        queue_cmd(bse_pkg::FN_INSERT,    1'b0, bse_pkg::ELEM_W'(CAPACITY - 1));
        queue_cmd(bse_pkg::FN_INSERT,    1'b0, bse_pkg::ELEM_W'(CAPACITY));
        queue_cmd(bse_pkg::FN_INSERT,    1'b0, ELEM_TOP);
        queue_cmd(bse_pkg::FN_MEMBER,    1'b0, bse_pkg::ELEM_W'(CAPACITY - 1));
        queue_cmd(bse_pkg::FN_MEMBER,    1'b0, ELEM_TOP);
        queue_cmd(bse_pkg::FN_MEMBER,    1'b1, '0);
        queue_cmd(bse_pkg::FN_EMPTY,     1'b1, '0);
        queue_cmd(bse_pkg::FN_CHOOSE,    1'b1, '0);
        queue_cmd(bse_pkg::FN_EMPTY,     1'b0, '0);
        queue_cmd(bse_pkg::FN_CHOOSE,    1'b0, '0);
        queue_cmd(bse_pkg::FN_DELETE,    1'b0, '0);
        queue_cmd(bse_pkg::FN_CHOOSE,    1'b0, '0);
        queue_cmd(bse_pkg::FN_DELETE,    1'b0, ELEM_TOP);
        queue_cmd(bse_pkg::FN_UNION,     1'b1, '0);
        queue_cmd(bse_pkg::FN_EQUAL,     1'b0, '0);
        queue_cmd(bse_pkg::FN_INSERT,    1'b1, 16'd500);
        queue_cmd(bse_pkg::FN_SUBSET,    1'b0, '0);
        queue_cmd(bse_pkg::FN_DISJOINT,  1'b0, '0);
        queue_cmd(bse_pkg::FN_INTERSECT, 1'b1, '0);
        queue_cmd(bse_pkg::FN_COPY,      1'b0, '0);
        queue_cmd(bse_pkg::FN_CLEAR,     1'b0, '0);
        queue_cmd(bse_pkg::FN_DISJOINT,  1'b0, '0);
        queue_cmd(FUNC_SPARE_LO, 1'b1, 16'hAAAA);
        queue_cmd(FUNC_SPARE_HI, 1'b0, 16'h5555);
        while (cmd_queue.size() != 0) @(posedge aclk);

        run_phase(0, 0, 120);
        run_phase(62, 0, 120);
        run_phase(0, 62, 120);
        run_phase(24, 24, 120);
        hold_go = 1'b1;
        run_phase(0, 0, 40);

        while (n_accepted != n_issued) @(posedge aclk);
        while (want_results.size() != 0) @(posedge aclk);
        repeat (2 * NUM_WORDS + 8) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
